// File: rtl/half_frame_brightness_meter_macros.svh
// assertion helpers for queue, divider and back, sampled on aclk
`ifndef HALF_FRAME_BRIGHTNESS_METER_MACROS_SVH
`define HALF_FRAME_BRIGHTNESS_METER_MACROS_SVH

// property must hold at every edge outside reset
`define HFBM_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (prop)) else $error(msg);

// expression must never be true outside reset
`define HFBM_NEVER(lbl, expr, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) !(expr)) else $error(msg);

`endif

// File: rtl/hfbm_pkg.sv
package hfbm_pkg;

    // pixel and result field widths
    localparam int CHAN_W      = 8;
    localparam int CHANNELS    = 3;
    localparam int PIX_SUM_W   = 10;
    localparam int SUM_W       = 31;
    localparam int TALLY_W     = 22;
    localparam int MEAN_W      = 8;
    localparam int BQ_W        = 18;
    localparam int STEP_W      = 4;
    localparam int IN_DATA_W   = 24;
    localparam int OUT_DATA_W  = 96;

    // configuration port
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 12;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_FRAME_WIDTH      = 3'd0,
        CFG_FRAME_HEIGHT     = 3'd1,
        CFG_USE_LOWER_HALF   = 3'd2,
        CFG_SAMPLE_STEP      = 3'd3,
        CFG_BRIGHT_THRESHOLD = 3'd4,
        CFG_DARK_THRESHOLD   = 3'd5
    } cfg_index_t;

    // register values after reset
    localparam logic [11:0]        RST_FRAME_WIDTH  = 12'd640;
    localparam logic [11:0]        RST_FRAME_HEIGHT = 12'd480;
    localparam logic               RST_LOWER_HALF   = 1'b0;
    localparam logic [STEP_W-1:0]  RST_SAMPLE_STEP  = 4'd5;
    localparam logic [CHAN_W-1:0]  RST_BRIGHT_TH    = 8'd250;
    localparam logic [CHAN_W-1:0]  RST_DARK_TH      = 8'd25;

    // saturation limits
    localparam logic [SUM_W-1:0]   SUM_MAX   = {SUM_W{1'b1}};
    localparam logic [TALLY_W-1:0] TALLY_MAX = {TALLY_W{1'b1}};

    // score scale: 100 in q8
    localparam logic signed [15:0] SCORE_SCALE = 16'sd25600;
    localparam int Q_FRAC = 8;

    // shared serial divider
    localparam int DIVD_W = 40;
    localparam int DIVS_W = 24;

    // accumulated totals of one finished frame
    typedef struct packed {
        logic [SUM_W-1:0]   sum;
        logic [TALLY_W-1:0] bright;
        logic [TALLY_W-1:0] dark;
        logic [TALLY_W-1:0] num;
    } frame_stats_t;

    typedef struct packed {
        logic              start;
        logic [DIVD_W-1:0] dividend;
        logic [DIVS_W-1:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic              busy;
        logic              done;
        logic [DIVD_W-1:0] quotient;
    } div_rsp_t;

endpackage

// File: rtl/hfbm_front.sv
module hfbm_front #(
    parameter int MAX_WIDTH  = 2048,
    parameter int MAX_HEIGHT = 2048
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [hfbm_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [hfbm_pkg::CFG_DATA_W-1:0]    cfg_data,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    input  logic [hfbm_pkg::IN_DATA_W-1:0]     s_tdata,
    input  logic                               s_tuser,
    output logic                               push,
    output hfbm_pkg::frame_stats_t             push_data,
    input  logic                               q_full
);
    import hfbm_pkg::*;

    localparam int COL_W = $clog2(MAX_WIDTH);
    localparam int ROW_W = $clog2(MAX_HEIGHT);
    localparam int WD_W  = COL_W + 1;
    localparam int HT_W  = ROW_W + 1;
    localparam int PW    = (COL_W > ROW_W) ? COL_W : ROW_W;
    localparam int CNT_W = $clog2(PW);

    typedef enum logic [1:0] {
        FR_RUN,
        FR_LOAD,
        FR_MOD
    } fr_state_t;

    fr_state_t state_reg, state_next;

    // configuration registers
    logic [11:0]        frame_width_reg, frame_width_next;
    logic [11:0]        frame_height_reg, frame_height_next;
    logic               lower_half_reg, lower_half_next;
    logic [STEP_W-1:0]  sample_step_reg, sample_step_next;
    logic [CHAN_W-1:0]  bright_th_reg, bright_th_next;
    logic [CHAN_W-1:0]  dark_th_reg, dark_th_next;

    // position, stride phases and accumulators
    logic [COL_W-1:0]   col_reg, col_next;
    logic [ROW_W-1:0]   row_reg, row_next;
    logic [STEP_W-1:0]  colph_reg, colph_next;
    logic [STEP_W-1:0]  rowph_reg, rowph_next;
    logic [SUM_W-1:0]   sum_reg, sum_next;
    logic [TALLY_W-1:0] bright_reg, bright_next;
    logic [TALLY_W-1:0] dark_reg, dark_next;
    logic [TALLY_W-1:0] num_reg, num_next;

    // phase recompute unit
    logic [PW-1:0]      mcol_dvd_reg, mcol_dvd_next;
    logic [PW-1:0]      mrow_dvd_reg, mrow_dvd_next;
    logic [STEP_W-1:0]  mcol_rem_reg, mcol_rem_next;
    logic [STEP_W-1:0]  mrow_rem_reg, mrow_rem_next;
    logic [CNT_W-1:0]   mcnt_reg, mcnt_next;

    logic [31:0]        w_full, h_full;
    logic [WD_W-1:0]    w_eff;
    logic [HT_W-1:0]    h_eff;
    logic [STEP_W-1:0]  step_eff;
    logic [ROW_W-1:0]   half_rows, first_row;
    logic [HT_W-1:0]    end_row;

    logic               accept, sof;
    logic [COL_W-1:0]   cur_col;
    logic [ROW_W-1:0]   cur_row;
    logic [STEP_W-1:0]  cur_colph, cur_rowph;
    logic [SUM_W-1:0]   sum_base;
    logic [TALLY_W-1:0] bright_base, dark_base, num_base;
    logic [CHAN_W-1:0]  c0, c1, c2;
    logic [PIX_SUM_W-1:0] pix_sum;
    logic [SUM_W:0]     sum_tmp;
    logic               in_rows, take, is_bright, is_dark, row_end, frame_end;
    logic [SUM_W-1:0]   sum_upd;
    logic [TALLY_W-1:0] bright_upd, dark_upd, num_upd;
    logic [STEP_W:0]    col_sh, row_sh;
    logic [STEP_W-1:0]  col_rem_new, row_rem_new;

    function automatic logic [TALLY_W-1:0] sat_inc(input logic [TALLY_W-1:0] v);
        sat_inc = (v == TALLY_MAX) ? v : v + 1'b1;
    endfunction

    // effective geometry
    always_comb begin
        if (frame_width_reg == '0) begin
            w_full = 32'd1;
        end else if (32'(frame_width_reg) > 32'(MAX_WIDTH)) begin
            w_full = 32'(MAX_WIDTH);
        end else begin
            w_full = 32'(frame_width_reg);
        end
        if (frame_height_reg == '0) begin
            h_full = 32'd1;
        end else if (32'(frame_height_reg) > 32'(MAX_HEIGHT)) begin
            h_full = 32'(MAX_HEIGHT);
        end else begin
            h_full = 32'(frame_height_reg);
        end
    end

    assign w_eff     = WD_W'(w_full);
    assign h_eff     = HT_W'(h_full);
    assign step_eff  = (sample_step_reg == '0) ? STEP_W'(1) : sample_step_reg;
    assign half_rows = ROW_W'(h_eff >> 1);
    assign first_row = lower_half_reg ? half_rows : '0;
    assign end_row   = {1'b0, first_row} + {1'b0, half_rows};

    assign cfg_ready = 1'b1;
    assign s_tready  = (state_reg == FR_RUN) && !q_full && !cfg_valid;
    assign accept    = s_tvalid && s_tready;
    assign sof       = s_tuser;

    // position as seen by this item, frame start taken first
    assign cur_col     = sof ? '0 : col_reg;
    assign cur_row     = sof ? '0 : row_reg;
    assign cur_colph   = sof ? '0 : colph_reg;
    assign cur_rowph   = sof ? '0 : rowph_reg;
    assign sum_base    = sof ? '0 : sum_reg;
    assign bright_base = sof ? '0 : bright_reg;
    assign dark_base   = sof ? '0 : dark_reg;
    assign num_base    = sof ? '0 : num_reg;

    // sample classification
    assign c0 = s_tdata[CHAN_W-1:0];
    assign c1 = s_tdata[2*CHAN_W-1:CHAN_W];
    assign c2 = s_tdata[3*CHAN_W-1:2*CHAN_W];
    assign pix_sum = PIX_SUM_W'(c0) + PIX_SUM_W'(c1) + PIX_SUM_W'(c2);

    assign in_rows = ({1'b0, cur_row} >= {1'b0, first_row}) && ({1'b0, cur_row} < end_row);
    assign take    = in_rows && (cur_rowph == '0) && (cur_colph == '0)
                     && ({1'b0, cur_col} < w_eff);
    assign is_bright = (c0 >= bright_th_reg) && (c1 >= bright_th_reg) && (c2 >= bright_th_reg);
    assign is_dark   = (c0 <= dark_th_reg) && (c1 <= dark_th_reg) && (c2 <= dark_th_reg);

    assign sum_tmp    = {1'b0, sum_base} + (SUM_W+1)'(pix_sum);
    assign sum_upd    = !take ? sum_base
                        : ((sum_tmp > {1'b0, SUM_MAX}) ? SUM_MAX : sum_tmp[SUM_W-1:0]);
    assign bright_upd = (take && is_bright) ? sat_inc(bright_base) : bright_base;
    assign dark_upd   = (take && is_dark) ? sat_inc(dark_base) : dark_base;
    assign num_upd    = take ? sat_inc(num_base) : num_base;

    assign row_end   = {1'b0, cur_col} >= (w_eff - 1'b1);
    assign frame_end = row_end && ({1'b0, cur_row} >= (h_eff - 1'b1));

    assign push             = accept && frame_end;
    assign push_data.sum    = sum_upd;
    assign push_data.bright = bright_upd;
    assign push_data.dark   = dark_upd;
    assign push_data.num    = num_upd;

    // one restoring step of the stride remainders
    assign col_sh      = {mcol_rem_reg, mcol_dvd_reg[PW-1]};
    assign row_sh      = {mrow_rem_reg, mrow_dvd_reg[PW-1]};
    assign col_rem_new = (col_sh >= {1'b0, step_eff}) ? STEP_W'(col_sh - {1'b0, step_eff})
                                                      : col_sh[STEP_W-1:0];
    assign row_rem_new = (row_sh >= {1'b0, step_eff}) ? STEP_W'(row_sh - {1'b0, step_eff})
                                                      : row_sh[STEP_W-1:0];

    // next state
    always_comb begin
        state_next        = state_reg;
        frame_width_next  = frame_width_reg;
        frame_height_next = frame_height_reg;
        lower_half_next   = lower_half_reg;
        sample_step_next  = sample_step_reg;
        bright_th_next    = bright_th_reg;
        dark_th_next      = dark_th_reg;
        col_next          = col_reg;
        row_next          = row_reg;
        colph_next        = colph_reg;
        rowph_next        = rowph_reg;
        sum_next          = sum_reg;
        bright_next       = bright_reg;
        dark_next         = dark_reg;
        num_next          = num_reg;
        mcol_dvd_next     = mcol_dvd_reg;
        mrow_dvd_next     = mrow_dvd_reg;
        mcol_rem_next     = mcol_rem_reg;
        mrow_rem_next     = mrow_rem_reg;
        mcnt_next         = mcnt_reg;

        // pixel path
        if (accept) begin
            if (frame_end) begin
                col_next    = '0;
                row_next    = '0;
                colph_next  = '0;
                rowph_next  = '0;
                sum_next    = '0;
                bright_next = '0;
                dark_next   = '0;
                num_next    = '0;
            end else begin
                sum_next    = sum_upd;
                bright_next = bright_upd;
                dark_next   = dark_upd;
                num_next    = num_upd;
                if (row_end) begin
                    col_next   = '0;
                    colph_next = '0;
                    row_next   = cur_row + 1'b1;
                    if (({1'b0, cur_row} + 1'b1) == {1'b0, first_row}) begin
                        rowph_next = '0;
                    end else if (cur_rowph == step_eff - 1'b1) begin
                        rowph_next = '0;
                    end else begin
                        rowph_next = cur_rowph + 1'b1;
                    end
                end else begin
                    col_next   = cur_col + 1'b1;
                    row_next   = cur_row;
                    rowph_next = cur_rowph;
                    colph_next = (cur_colph == step_eff - 1'b1) ? '0 : cur_colph + 1'b1;
                end
            end
        end

        // stride phase recompute after a register write
        case (state_reg)
            FR_RUN: begin
            end
            FR_LOAD: begin
                mcol_dvd_next = PW'(col_reg);
                mrow_dvd_next = (row_reg >= first_row) ? PW'(row_reg - first_row) : '0;
                mcol_rem_next = '0;
                mrow_rem_next = '0;
                mcnt_next     = '0;
                state_next    = FR_MOD;
            end
            FR_MOD: begin
                mcol_rem_next = col_rem_new;
                mrow_rem_next = row_rem_new;
                mcol_dvd_next = {mcol_dvd_reg[PW-2:0], 1'b0};
                mrow_dvd_next = {mrow_dvd_reg[PW-2:0], 1'b0};
                mcnt_next     = mcnt_reg + 1'b1;
                if (mcnt_reg == CNT_W'(PW - 1)) begin
                    colph_next = col_rem_new;
                    rowph_next = row_rem_new;
                    state_next = FR_RUN;
                end
            end
            default: state_next = FR_RUN;
        endcase

        // register writes
        if (cfg_valid && cfg_ready) begin
            state_next = FR_LOAD;
            case (cfg_index_t'(cfg_index))
                CFG_FRAME_WIDTH:      frame_width_next  = cfg_data;
                CFG_FRAME_HEIGHT:     frame_height_next = cfg_data;
                CFG_USE_LOWER_HALF:   lower_half_next   = cfg_data[0];
                CFG_SAMPLE_STEP:      sample_step_next  = cfg_data[STEP_W-1:0];
                CFG_BRIGHT_THRESHOLD: bright_th_next    = cfg_data[CHAN_W-1:0];
                CFG_DARK_THRESHOLD:   dark_th_next      = cfg_data[CHAN_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg        <= FR_RUN;
            frame_width_reg  <= RST_FRAME_WIDTH;
            frame_height_reg <= RST_FRAME_HEIGHT;
            lower_half_reg   <= RST_LOWER_HALF;
            sample_step_reg  <= RST_SAMPLE_STEP;
            bright_th_reg    <= RST_BRIGHT_TH;
            dark_th_reg      <= RST_DARK_TH;
            col_reg          <= '0;
            row_reg          <= '0;
            colph_reg        <= '0;
            rowph_reg        <= '0;
            sum_reg          <= '0;
            bright_reg       <= '0;
            dark_reg         <= '0;
            num_reg          <= '0;
            mcnt_reg         <= '0;
        end else begin
            state_reg        <= state_next;
            frame_width_reg  <= frame_width_next;
            frame_height_reg <= frame_height_next;
            lower_half_reg   <= lower_half_next;
            sample_step_reg  <= sample_step_next;
            bright_th_reg    <= bright_th_next;
            dark_th_reg      <= dark_th_next;
            col_reg          <= col_next;
            row_reg          <= row_next;
            colph_reg        <= colph_next;
            rowph_reg        <= rowph_next;
            sum_reg          <= sum_next;
            bright_reg       <= bright_next;
            dark_reg         <= dark_next;
            num_reg          <= num_next;
            mcnt_reg         <= mcnt_next;
        end
        mcol_dvd_reg <= mcol_dvd_next;
        mrow_dvd_reg <= mrow_dvd_next;
        mcol_rem_reg <= mcol_rem_next;
        mrow_rem_reg <= mrow_rem_next;
    end

endmodule

// File: rtl/hfbm_queue.sv
`include "half_frame_brightness_meter_macros.svh"

module hfbm_queue (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   push,
    input  hfbm_pkg::frame_stats_t push_data,
    output logic                   full,
    input  logic                   pop,
    output hfbm_pkg::frame_stats_t pop_data,
    output logic                   empty
);
    import hfbm_pkg::*;

    localparam int DEPTH = 2;
    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    frame_stats_t     mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;

    assign full     = (count_reg == CNT_W'(DEPTH));
    assign empty    = (count_reg == '0);
    assign pop_data = mem_reg[rd_ptr_reg];

    // pointers and fill level
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (push && !pop) begin
                count_reg <= count_reg + 1'b1;
            end else if (pop && !push) begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    // entry storage
    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

    `HFBM_NEVER(a_no_push_full, push && full, "frame totals pushed into a full queue")
    `HFBM_NEVER(a_no_pop_empty, pop && empty, "frame totals popped from an empty queue")

endmodule

// File: rtl/hfbm_divider.sv
`include "half_frame_brightness_meter_macros.svh"

module hfbm_divider (
    input  logic               aclk,
    input  logic               aresetn,
    input  hfbm_pkg::div_req_t req,
    output hfbm_pkg::div_rsp_t rsp
);
    import hfbm_pkg::*;

    localparam int CNT_W = $clog2(DIVD_W);

    logic              busy_reg, done_reg;
    logic [CNT_W-1:0]  cnt_reg;
    logic [DIVD_W-1:0] dvd_reg;
    logic [DIVS_W-1:0] dvs_reg;
    logic [DIVS_W-1:0] rem_reg;
    logic [DIVS_W:0]   rem_sh;
    logic              ge;
    logic [DIVS_W-1:0] rem_new;

    // one restoring quotient bit per cycle
    assign rem_sh  = {rem_reg, dvd_reg[DIVD_W-1]};
    assign ge      = rem_sh >= {1'b0, dvs_reg};
    assign rem_new = ge ? DIVS_W'(rem_sh - {1'b0, dvs_reg}) : rem_sh[DIVS_W-1:0];

    assign rsp.busy     = busy_reg;
    assign rsp.done     = done_reg;
    assign rsp.quotient = dvd_reg;

    // control
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (!busy_reg && req.start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(DIVD_W - 1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // datapath
    always_ff @(posedge aclk) begin
        if (!busy_reg && req.start) begin
            dvd_reg <= req.dividend;
            dvs_reg <= req.divisor;
            rem_reg <= '0;
        end else if (busy_reg) begin
            dvd_reg <= {dvd_reg[DIVD_W-2:0], ge};
            rem_reg <= rem_new;
        end
    end

    `HFBM_NEVER(a_start_idle, req.start && busy_reg, "divider started while busy")
    `HFBM_ASSERT(a_done_after_busy, done_reg |-> $past(busy_reg), "done without a run")

endmodule

// File: rtl/hfbm_back.sv
`include "half_frame_brightness_meter_macros.svh"

module hfbm_back (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  hfbm_pkg::frame_stats_t          pop_data,
    input  logic                            empty,
    output logic                            pop,
    output hfbm_pkg::div_req_t              div_req,
    input  hfbm_pkg::div_rsp_t              div_rsp,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [hfbm_pkg::OUT_DATA_W-1:0] m_tdata,
    output logic                            m_tuser
);
    import hfbm_pkg::*;

    localparam int PA_W = MEAN_W + TALLY_W;
    localparam int DF_W = TALLY_W + 1;
    localparam int PB_W = DF_W + 16;

    typedef enum logic [2:0] {
        B_IDLE,
        B_MEAN_GO,
        B_MEAN_WAIT,
        B_MUL,
        B_ADD,
        B_Q_GO,
        B_Q_WAIT,
        B_EMIT
    } b_state_t;

    b_state_t state_reg;

    frame_stats_t             stats_reg;
    logic [MEAN_W-1:0]        mean_reg;
    logic [PA_W-1:0]          prod_a_reg;
    logic signed [PB_W-1:0]   prod_b_reg;
    logic signed [DIVD_W-1:0] numer_reg;
    logic                     neg_reg;
    logic                     zero_reg;
    logic [BQ_W-1:0]          bq_reg;
    logic                     m_tvalid_reg;
    logic [OUT_DATA_W-1:0]    m_tdata_reg;
    logic                     m_tuser_reg;

    logic signed [DF_W-1:0]   diff;
    logic [DIVD_W-1:0]        numer_abs;
    logic [DIVD_W-1:0]        q_signed;
    logic                     out_free;
    logic                     emit_go;
    logic                     div_wait;

    assign pop      = (state_reg == B_IDLE) && !empty;
    assign out_free = !m_tvalid_reg || m_tready;
    assign emit_go  = (state_reg == B_EMIT) && out_free;
    assign div_wait = (state_reg == B_MEAN_WAIT) || (state_reg == B_Q_WAIT);

    assign diff      = $signed({1'b0, stats_reg.bright}) - $signed({1'b0, stats_reg.dark});
    assign numer_abs = numer_reg[DIVD_W-1] ? DIVD_W'(-numer_reg) : DIVD_W'(numer_reg);
    assign q_signed  = neg_reg ? DIVD_W'(-div_rsp.quotient) : div_rsp.quotient;

    // divider requests: sum / (3 * num), then |numerator| / num
    always_comb begin
        div_req.start    = 1'b0;
        div_req.dividend = DIVD_W'(stats_reg.sum);
        div_req.divisor  = DIVS_W'({stats_reg.num, 1'b0}) + DIVS_W'(stats_reg.num);
        case (state_reg)
            B_MEAN_GO: div_req.start = 1'b1;
            B_Q_GO: begin
                div_req.start    = 1'b1;
                div_req.dividend = numer_abs;
                div_req.divisor  = DIVS_W'(stats_reg.num);
            end
            default: begin
            end
        endcase
    end

    // sequencer and output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= B_IDLE;
            m_tvalid_reg <= 1'b0;
        end else begin
            // result valid: set on a new result, cleared once taken
            if (emit_go) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tvalid_reg && m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
            case (state_reg)
                B_IDLE: begin
                    if (!empty) begin
                        stats_reg <= pop_data;
                        if (pop_data.num == '0) begin
                            zero_reg  <= 1'b1;
                            mean_reg  <= '0;
                            bq_reg    <= '0;
                            state_reg <= B_EMIT;
                        end else begin
                            zero_reg  <= 1'b0;
                            state_reg <= B_MEAN_GO;
                        end
                    end
                end
                B_MEAN_GO: state_reg <= B_MEAN_WAIT;
                B_MEAN_WAIT: begin
                    if (div_rsp.done) begin
                        mean_reg  <= div_rsp.quotient[MEAN_W-1:0];
                        state_reg <= B_MUL;
                    end
                end
                B_MUL: begin
                    prod_a_reg <= PA_W'(mean_reg) * PA_W'(stats_reg.num);
                    prod_b_reg <= PB_W'(diff) * PB_W'(SCORE_SCALE);
                    state_reg  <= B_ADD;
                end
                B_ADD: begin
                    numer_reg <= $signed({{(DIVD_W-PA_W-Q_FRAC){1'b0}}, prod_a_reg,
                                          {Q_FRAC{1'b0}}}) + DIVD_W'(prod_b_reg);
                    state_reg <= B_Q_GO;
                end
                B_Q_GO: begin
                    neg_reg   <= numer_reg[DIVD_W-1];
                    state_reg <= B_Q_WAIT;
                end
                B_Q_WAIT: begin
                    if (div_rsp.done) begin
                        bq_reg    <= q_signed[BQ_W-1:0];
                        state_reg <= B_EMIT;
                    end
                end
                B_EMIT: begin
                    if (out_free) begin
                        m_tuser_reg  <= zero_reg;
                        if (zero_reg) begin
                            m_tdata_reg <= '0;
                        end else begin
                            m_tdata_reg <= {{(OUT_DATA_W-BQ_W-MEAN_W-3*TALLY_W){1'b0}},
                                            stats_reg.num, stats_reg.dark, stats_reg.bright,
                                            mean_reg, bq_reg};
                        end
                        state_reg <= B_IDLE;
                    end
                end
                default: state_reg <= B_IDLE;
            endcase
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

    `HFBM_NEVER(a_empty_zeroed, m_tvalid && m_tuser && (|m_tdata), "empty result not zero")
    `HFBM_ASSERT(a_done_expected, div_rsp.done |-> div_wait, "divider result not awaited")

endmodule

// File: rtl/half_frame_brightness_meter.sv
// a frame result is shown after its last pixel is taken and two 40-step divisions
//   have run in one shared bit-serial divider
// throughput: one pixel per cycle; the input stalls while the queue is full, while a
//   register write is offered and after it while the stride phases are recomputed
// up to two finished frames wait in the queue while the divider works
// reset: aresetn synchronous active low; registers return to 640x480, top half,
//   step 5, thresholds 250 and 25, position and totals cleared
module half_frame_brightness_meter #(
    parameter int MAX_WIDTH  = 2048,
    parameter int MAX_HEIGHT = 2048
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    // configuration writes
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [hfbm_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [hfbm_pkg::CFG_DATA_W-1:0] cfg_data,
    // pixel input
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [hfbm_pkg::IN_DATA_W-1:0]  s_tdata,  // chan_first, chan_second, chan_third
    input  logic                            s_tuser,  // frame_start
    // frame results
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // brightness_q8, mean_level, bright_count, dark_count, sample_count, zero pad
    output logic [hfbm_pkg::OUT_DATA_W-1:0] m_tdata,
    output logic                            m_tuser   // no_samples
);
    import hfbm_pkg::*;

    logic         push, q_full, pop, q_empty;
    frame_stats_t push_data, pop_data;
    div_req_t     div_req;
    div_rsp_t     div_rsp;

    // position tracking and accumulation
    hfbm_front #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .push      (push),
        .push_data (push_data),
        .q_full    (q_full)
    );

    // finished frame totals
    hfbm_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_data (push_data),
        .full      (q_full),
        .pop       (pop),
        .pop_data  (pop_data),
        .empty     (q_empty)
    );

    // shared serial divider
    hfbm_divider u_divider (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (div_req),
        .rsp     (div_rsp)
    );

    // end of frame arithmetic and result register
    hfbm_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .pop_data (pop_data),
        .empty    (q_empty),
        .pop      (pop),
        .div_req  (div_req),
        .div_rsp  (div_rsp),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

endmodule
